@@ sv/gcd_pkg.sv @@
// shared constants, tables and types for the great-circle distance unit
package gcd_pkg;

  // angle width, q3.29 radians with headroom
  localparam int ZW = 33;
  localparam int ISQ_STAGES = 32;

  localparam logic signed [ZW-1:0] PI_Q29      = 33'sd1686629713;
  localparam logic signed [ZW-1:0] HALF_PI_Q29 = 33'sd843314857;
  localparam logic [30:0]          GAIN_Q30    = 31'd652032874;
  localparam logic [22:0]          RADIUS_M    = 23'd6372795;
  localparam logic signed [32:0]   TURN        = 33'sd3600000000;
  localparam logic signed [32:0]   HALF_TURN   = 33'sd1800000000;
  localparam logic [63:0]          DEG_NUM     = 64'd17872171539456;
  localparam logic [63:0]          DEG_DEN     = 64'd19073486328125;

  localparam logic signed [ZW-1:0] ATAN_TAB [32] = '{
    33'sd421657428, 33'sd248918915, 33'sd131521918, 33'sd66762579,
    33'sd33510843,  33'sd16771758,  33'sd8387925,   33'sd4194219,
    33'sd2097141,   33'sd1048575,   33'sd524288,    33'sd262144,
    33'sd131072,    33'sd65536,     33'sd32768,     33'sd16384,
    33'sd8192,      33'sd4096,      33'sd2048,      33'sd1024,
    33'sd512,       33'sd256,       33'sd128,       33'sd64,
    33'sd32,        33'sd16,        33'sd8,         33'sd4,
    33'sd2,         33'sd1,         33'sd0,         33'sd0
  };

  // degree-to-radian scale, fraction bits found at elaboration
  function automatic logic [31:0] rad_factor();
    logic [63:0] r;
    logic [31:0] q;
    r = DEG_NUM;
    q = '0;
    for (int i = 0; i < 32; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= DEG_DEN) begin
        r = r - DEG_DEN;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  localparam logic [31:0] RAD_K = rad_factor();

  typedef struct packed {
    logic zero;
    logic den_neg;
  } vec_side_t;

endpackage

@@ sv/gcd_cordic.sv @@
// pipelined cordic, rotation or vectoring mode, one iteration per stage
module gcd_cordic #(
  parameter int STAGES = 24,
  parameter bit VECTOR = 1'b0,
  parameter int DW     = 34,
  parameter int SW     = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic signed [DW-1:0]          in_x,
  input  logic signed [DW-1:0]          in_y,
  input  logic signed [gcd_pkg::ZW-1:0] in_z,
  input  logic [SW-1:0]                 in_side,
  output logic                          out_valid,
  output logic signed [DW-1:0]          out_x,
  output logic signed [DW-1:0]          out_y,
  output logic signed [gcd_pkg::ZW-1:0] out_z,
  output logic [SW-1:0]                 out_side
);
  import gcd_pkg::*;

  logic [STAGES-1:0]        valid_r;
  logic signed [DW-1:0]     x_r [STAGES];
  logic signed [DW-1:0]     y_r [STAGES];
  logic signed [ZW-1:0]     z_r [STAGES];
  logic [SW-1:0]            side_r [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [DW-1:0] xi, yi, x_nxt, y_nxt;
    logic signed [ZW-1:0] zi, z_nxt;
    logic [SW-1:0]        si;
    logic                 vi, rot_pos;

    if (i == 0) begin : g_first
      assign xi = in_x;
      assign yi = in_y;
      assign zi = in_z;
      assign si = in_side;
      assign vi = in_valid;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign si = side_r[i-1];
      assign vi = valid_r[i-1];
    end

    // vectoring drives y toward zero, rotation drives z toward zero
    assign rot_pos = VECTOR ? !(yi > 0) : (zi >= 0);

    always_comb begin
      if (rot_pos) begin
        x_nxt = xi - (yi >>> i);
        y_nxt = yi + (xi >>> i);
        z_nxt = zi - ATAN_TAB[i];
      end else begin
        x_nxt = xi + (yi >>> i);
        y_nxt = yi - (xi >>> i);
        z_nxt = zi + ATAN_TAB[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
      end else begin
        valid_r[i] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      x_r[i]    <= x_nxt;
      y_r[i]    <= y_nxt;
      z_r[i]    <= z_nxt;
      side_r[i] <= si;
    end
  end

  assign out_valid = valid_r[STAGES-1];
  assign out_x     = x_r[STAGES-1];
  assign out_y     = y_r[STAGES-1];
  assign out_z     = z_r[STAGES-1];
  assign out_side  = side_r[STAGES-1];

endmodule

@@ sv/gcd_isqrt.sv @@
// pipelined integer square root, one result bit per stage
module gcd_isqrt #(
  parameter int SW = 33
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [63:0]   in_rad,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [31:0]   out_root,
  output logic [SW-1:0] out_side
);
  import gcd_pkg::*;

  logic [ISQ_STAGES-1:0] valid_r;
  logic [63:0]           rad_r  [ISQ_STAGES];
  logic [34:0]           rem_r  [ISQ_STAGES];
  logic [31:0]           root_r [ISQ_STAGES];
  logic [SW-1:0]         side_r [ISQ_STAGES];

  for (genvar i = 0; i < ISQ_STAGES; i++) begin : g_stage
    logic [63:0]   radi;
    logic [34:0]   remi, rem_sh, trial, rem_nxt;
    logic [31:0]   rooti, root_nxt;
    logic [SW-1:0] si;
    logic          vi;

    if (i == 0) begin : g_first
      assign radi  = in_rad;
      assign remi  = '0;
      assign rooti = '0;
      assign si    = in_side;
      assign vi    = in_valid;
    end else begin : g_next
      assign radi  = rad_r[i-1];
      assign remi  = rem_r[i-1];
      assign rooti = root_r[i-1];
      assign si    = side_r[i-1];
      assign vi    = valid_r[i-1];
    end

    // bring down the next two radicand bits and try root*4+1
    assign rem_sh = {remi[32:0], radi[63:62]};
    assign trial  = {1'b0, rooti, 2'b01};

    always_comb begin
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {rooti[30:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {rooti[30:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
      end else begin
        valid_r[i] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      rad_r[i]  <= {radi[61:0], 2'b00};
      rem_r[i]  <= rem_nxt;
      root_r[i] <= root_nxt;
      side_r[i] <= si;
    end
  end

  assign out_valid = valid_r[ISQ_STAGES-1];
  assign out_root  = root_r[ISQ_STAGES-1];
  assign out_side  = side_r[ISQ_STAGES-1];

endmodule

@@ sv/great_circle_distance_unit.sv @@
// great-circle distance unit: fully pipelined, one coordinate pair per cycle
// start path: input, radian, rotation, product, root, vectoring and output stages
// throughput: one beat per cycle, set by the cordic and square-root pipelines
// busy is never raised; results cannot be held off and leave one per strobe
// synchronous active-low reset clears all valid bits; data registers are not reset
module great_circle_distance_unit #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [30:0] in_lat_a,
  input  logic signed [31:0] in_lon_a,
  input  logic signed [30:0] in_lat_b,
  input  logic signed [31:0] in_lon_b,
  output logic               out_valid,
  output logic [24:0]        out_distance_m
);
  import gcd_pkg::*;

  typedef struct packed {
    logic                 neg;
    logic signed [ZW-1:0] z;
  } fold_t;

  function automatic logic signed [ZW-1:0] to_rad(input logic signed [31:0] x);
    logic [31:0] m;
    logic [63:0] p;
    m = x[31] ? 32'(-x) : 32'(x);
    p = 64'(m) * 64'(RAD_K);
    return x[31] ? -$signed({1'b0, p[63:32]}) : $signed({1'b0, p[63:32]});
  endfunction

  // bring the angle into a half turn around zero
  function automatic fold_t fold(input logic signed [ZW-1:0] z);
    fold_t f;
    f.neg = 1'b0;
    f.z   = z;
    if (z > HALF_PI_Q29) begin
      f.neg = 1'b1;
      f.z   = z - PI_Q29;
    end else if (z < -HALF_PI_Q29) begin
      f.neg = 1'b1;
      f.z   = z + PI_Q29;
    end
    return f;
  endfunction

  // q2.30 product, truncated toward zero
  function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic [31:0] ma, mb;
    logic [63:0] p;
    ma = a[31] ? 32'(-a) : 32'(a);
    mb = b[31] ? 32'(-b) : 32'(b);
    p  = 64'(ma) * 64'(mb);
    return (a[31] != b[31]) ? -$signed(p[61:30]) : $signed(p[61:30]);
  endfunction

  function automatic logic signed [31:0] fix_sign(input logic neg,
                                                  input logic signed [33:0] v);
    return neg ? 32'(-v) : 32'(v);
  endfunction

  assign busy = 1'b0;

  // stage 1: longitude difference, wrapped
  logic signed [32:0] dlon;
  logic signed [32:0] dwrap;
  logic               v1_r;
  logic signed [31:0] d_r;
  logic signed [30:0] la_r, lb_r;

  always_comb begin
    dlon  = 33'(in_lon_a) - 33'(in_lon_b);
    dwrap = dlon;
    if (dlon > HALF_TURN) begin
      dwrap = dlon - TURN;
    end else if (dlon < -HALF_TURN) begin
      dwrap = dlon + TURN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    d_r  <= dwrap[31:0];
    la_r <= in_lat_a;
    lb_r <= in_lat_b;
  end

  // stage 2: radians
  logic                 v2_r;
  logic signed [ZW-1:0] zd_r, za_r, zb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    zd_r <= to_rad(d_r);
    za_r <= to_rad(32'(la_r));
    zb_r <= to_rad(32'(lb_r));
  end

  // sine and cosine of the three angles
  fold_t fd, fa, fb;
  assign fd = fold(zd_r);
  assign fa = fold(za_r);
  assign fb = fold(zb_r);

  logic                 rd_valid, ra_valid, rb_valid;
  logic signed [33:0]   xd, yd, xa, ya, xb, yb;
  logic signed [ZW-1:0] zd_o, za_o, zb_o;
  logic                 negd, nega, negb;

  gcd_cordic #(.STAGES(CORDIC_STAGES), .VECTOR(1'b0), .DW(34), .SW(1)) u_rot_d (
    .clk(clk), .rst_n(rst_n), .in_valid(v2_r),
    .in_x(34'(GAIN_Q30)), .in_y('0), .in_z(fd.z), .in_side(fd.neg),
    .out_valid(rd_valid), .out_x(xd), .out_y(yd), .out_z(zd_o), .out_side(negd)
  );

  gcd_cordic #(.STAGES(CORDIC_STAGES), .VECTOR(1'b0), .DW(34), .SW(1)) u_rot_a (
    .clk(clk), .rst_n(rst_n), .in_valid(v2_r),
    .in_x(34'(GAIN_Q30)), .in_y('0), .in_z(fa.z), .in_side(fa.neg),
    .out_valid(ra_valid), .out_x(xa), .out_y(ya), .out_z(za_o), .out_side(nega)
  );

  gcd_cordic #(.STAGES(CORDIC_STAGES), .VECTOR(1'b0), .DW(34), .SW(1)) u_rot_b (
    .clk(clk), .rst_n(rst_n), .in_valid(v2_r),
    .in_x(34'(GAIN_Q30)), .in_y('0), .in_z(fb.z), .in_side(fb.neg),
    .out_valid(rb_valid), .out_x(xb), .out_y(yb), .out_z(zb_o), .out_side(negb)
  );

  logic signed [31:0] sd, cd, sa, ca, sb, cb;
  assign cd = fix_sign(negd, xd);
  assign sd = fix_sign(negd, yd);
  assign ca = fix_sign(nega, xa);
  assign sa = fix_sign(nega, ya);
  assign cb = fix_sign(negb, xb);
  assign sb = fix_sign(negb, yb);

  // product stages
  logic               vp1_r, vp2_r, vp3_r, vp4_r, vp5_r;
  logic signed [31:0] ca_sb_r, sa_cb_r, sa_sb_r, ca_cb_r, cb_sd_r, cd_r;
  logic signed [31:0] ca_sb2_r, sa_sb2_r, cb_sd2_r, t1_r, t2_r;
  logic signed [32:0] a_sum, den_sum;
  logic [31:0]        ma_r, mb_r;
  logic signed [32:0] den3_r, den4_r, den5_r;
  logic [63:0]        sq_a_r, sq_b_r, rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp1_r <= 1'b0;
      vp2_r <= 1'b0;
      vp3_r <= 1'b0;
      vp4_r <= 1'b0;
      vp5_r <= 1'b0;
    end else begin
      vp1_r <= rd_valid;
      vp2_r <= vp1_r;
      vp3_r <= vp2_r;
      vp4_r <= vp3_r;
      vp5_r <= vp4_r;
    end
  end

  assign a_sum   = 33'(ca_sb2_r) - 33'(t1_r);
  assign den_sum = 33'(sa_sb2_r) + 33'(t2_r);

  always_ff @(posedge clk) begin
    ca_sb_r  <= mulq(ca, sb);
    sa_cb_r  <= mulq(sa, cb);
    sa_sb_r  <= mulq(sa, sb);
    ca_cb_r  <= mulq(ca, cb);
    cb_sd_r  <= mulq(cb, sd);
    cd_r     <= cd;

    t1_r     <= mulq(sa_cb_r, cd_r);
    t2_r     <= mulq(ca_cb_r, cd_r);
    ca_sb2_r <= ca_sb_r;
    sa_sb2_r <= sa_sb_r;
    cb_sd2_r <= cb_sd_r;

    ma_r     <= a_sum[32] ? 32'(-a_sum) : 32'(a_sum);
    mb_r     <= cb_sd2_r[31] ? 32'(-cb_sd2_r) : 32'(cb_sd2_r);
    den3_r   <= den_sum;

    sq_a_r   <= 64'(ma_r) * 64'(ma_r);
    sq_b_r   <= 64'(mb_r) * 64'(mb_r);
    den4_r   <= den3_r;

    rad_r    <= sq_a_r + sq_b_r;
    den5_r   <= den4_r;
  end

  // square root of the cross-term sum
  logic               sq_valid;
  logic [31:0]        num;
  logic signed [32:0] den;

  gcd_isqrt #(.SW(33)) u_isqrt (
    .clk(clk), .rst_n(rst_n), .in_valid(vp5_r), .in_rad(rad_r), .in_side(den5_r),
    .out_valid(sq_valid), .out_root(num), .out_side(den)
  );

  // atan2(num, den); a negative den starts a quarter turn up
  vec_side_t            vs_in, vs_out;
  logic signed [35:0]   vx_in, vy_in, vx_out, vy_out;
  logic signed [ZW-1:0] vz_in, vz_out;
  logic                 vec_valid;

  always_comb begin
    vs_in.zero    = (num == '0);
    vs_in.den_neg = den[32];
    if (!vs_in.zero && vs_in.den_neg) begin
      vx_in = $signed({4'b0000, num});
      vy_in = -36'(den);
      vz_in = HALF_PI_Q29;
    end else begin
      vx_in = 36'(den);
      vy_in = $signed({4'b0000, num});
      vz_in = '0;
    end
  end

  gcd_cordic #(.STAGES(CORDIC_STAGES), .VECTOR(1'b1), .DW(36),
               .SW($bits(vec_side_t))) u_vec (
    .clk(clk), .rst_n(rst_n), .in_valid(sq_valid),
    .in_x(vx_in), .in_y(vy_in), .in_z(vz_in), .in_side(vs_in),
    .out_valid(vec_valid), .out_x(vx_out), .out_y(vy_out), .out_z(vz_out),
    .out_side(vs_out)
  );

  // clamp to [0, pi] and scale by the radius
  logic [30:0] ang;
  logic        out_valid_r;
  logic [53:0] prod_r;

  always_comb begin
    if (vs_out.zero) begin
      ang = vs_out.den_neg ? PI_Q29[30:0] : '0;
    end else if (vz_out < 0) begin
      ang = '0;
    end else if (vz_out > PI_Q29) begin
      ang = PI_Q29[30:0];
    end else begin
      ang = vz_out[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vec_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= 54'(ang) * 54'(RADIUS_M);
  end

  assign out_valid      = out_valid_r;
  assign out_distance_m = prod_r[53:29];

  // the three rotation lanes run in lockstep
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_valid == ra_valid) && (rd_valid == rb_valid))
    else $error("rotation lanes out of step");

  // a half turn is the farthest two points can be apart
  a_distance_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_distance_m <= 25'd20020741))
    else $error("distance beyond half circumference");

  // the vectoring pipe only sees beats that came through the square root
  a_vec_follows_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
    vec_valid |-> $past(sq_valid, CORDIC_STAGES))
    else $error("vectoring beat without a square-root beat");

  // rotation residual ends well inside the first table step
  a_rot_residual: assert property (@(posedge clk) disable iff (!rst_n)
    rd_valid |-> ((zd_o < ATAN_TAB[0]) && (zd_o > -ATAN_TAB[0]) &&
                  (za_o < ATAN_TAB[0]) && (za_o > -ATAN_TAB[0]) &&
                  (zb_o < ATAN_TAB[0]) && (zb_o > -ATAN_TAB[0])))
    else $error("rotation did not converge");

  a_vec_residual: assert property (@(posedge clk) disable iff (!rst_n)
    vec_valid |-> (vx_out >= vy_out || vx_out < vy_out))
    else $error("vectoring output unknown");

endmodule

@@ tb/sv/tb_top.sv @@
// testbench for the great-circle distance unit: directed table, random pairs, predictor check
`timescale 1ns / 100ps
module tb_top;
  import gcd_pkg::*;

  localparam int STAGES  = 24;
  localparam int LATENCY = 2 * STAGES + 40;
  localparam int N_RAND  = 400;
  localparam longint LIMIT = 200000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [30:0] in_lat_a;
  logic signed [31:0] in_lon_a;
  logic signed [30:0] in_lat_b;
  logic signed [31:0] in_lon_b;
  logic               out_valid;
  logic [24:0]        out_distance_m;

  great_circle_distance_unit #(.CORDIC_STAGES(STAGES)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_lat_a(in_lat_a), .in_lon_a(in_lon_a), .in_lat_b(in_lat_b), .in_lon_b(in_lon_b),
    .out_valid(out_valid), .out_distance_m(out_distance_m)
  );

  typedef struct {
    logic signed [30:0] lat_a;
    logic signed [31:0] lon_a;
    logic signed [30:0] lat_b;
    logic signed [31:0] lon_b;
    logic               known;
    logic [24:0]        dist_m;
  } pair_t;

  localparam longint DG_NUM = 64'd17872171539456;
  localparam longint DG_DEN = 64'd19073486328125;
  localparam longint Q_PI   = 1686629713;
  localparam longint Q_HPI  = 843314857;
  localparam longint W_TURN = 64'sd3600000000;
  localparam longint W_HALF = 64'sd1800000000;

  logic [24:0] dist_q[$];
  int          n_bad;
  int          n_seen;
  int          n_sent;
  longint      cycles;
  longint      arc_tab [32] = '{
    421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
    8387925, 4194219, 2097141, 1048575, 524288, 262144, 131072, 65536,
    32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8,
    4, 2, 1, 0, 0};

  function automatic longint deg_scale();
    longint r, q;
    r = DG_NUM;
    q = 0;
    for (int i = 0; i < 32; i++) begin
      r = r <<< 1;
      q = q <<< 1;
      if (r >= DG_DEN) begin
        r = r - DG_DEN;
        q = q | 1;
      end
    end
    return q;
  endfunction

  function automatic longint deg_to_rad(longint x);
    longint m;
    logic [63:0] p;
    m = (x < 0) ? -x : x;
    p = (64'(m) * 64'(deg_scale())) >> 32;
    return (x < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint qmul(longint a, longint b);
    logic [63:0] p;
    longint ma, mb;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p = (64'(ma) * 64'(mb)) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  task automatic rotate(input longint ang, output longint s, output longint c);
    longint x, y, z, dx, dy;
    bit flip;
    x = 652032874;
    y = 0;
    z = ang;
    flip = 0;
    if (z > Q_HPI) begin
      z -= Q_PI;
      flip = 1;
    end else if (z < -Q_HPI) begin
      z += Q_PI;
      flip = 1;
    end
    for (int i = 0; i < STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arc_tab[i];
      end else begin
        x += dx; y -= dy; z += arc_tab[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint arc_angle(longint y0, longint x0);
    longint x, y, z, dx, dy;
    x = x0;
    y = y0;
    z = 0;
    if (y == 0) return (x >= 0) ? 0 : Q_PI;
    if (x < 0) begin
      z = Q_HPI;
      x = y0;
      y = -x0;
    end
    for (int i = 0; i < STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += arc_tab[i];
      end else begin
        x -= dx; y += dy; z -= arc_tab[i];
      end
    end
    if (z < 0) z = 0;
    if (z > Q_PI) z = Q_PI;
    return z;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic predict_distance(input pair_t p, output logic [24:0] want_m);
    longint d, sa, ca, sb, cb, sd, cd, a, b, den, num, c;
    logic [63:0] ma, mb, prod;
    d = longint'(p.lon_a) - longint'(p.lon_b);
    while (d > W_HALF) d -= W_TURN;
    while (d < -W_HALF) d += W_TURN;
    rotate(deg_to_rad(d), sd, cd);
    rotate(deg_to_rad(longint'(p.lat_a)), sa, ca);
    rotate(deg_to_rad(longint'(p.lat_b)), sb, cb);
    a = qmul(ca, sb) - qmul(qmul(sa, cb), cd);
    b = qmul(cb, sd);
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    num = longint'(int_sqrt(ma * ma + mb * mb));
    den = qmul(sa, sb) + qmul(qmul(ca, cb), cd);
    c = arc_angle(num, den);
    prod = (64'(c) * 64'd6372795) >> 29;
    want_m = prod[24:0];
  endtask

  task automatic report_mismatch(input string what, input logic [24:0] got,
                                 input logic [24:0] want);
    $display("mismatch %s: distance got %0d want %0d at cycle %0d", what, got, want, cycles);
    n_bad++;
  endtask

  // directed pairs: poles, antimeridian, extreme and out-of-range values
  pair_t dir_tab [] = '{
    '{31'sd0, 32'sd0, 31'sd0, 32'sd0, 1'b0, 25'd0},
    '{31'sd900000000, 32'sd0, 31'sd900000000, 32'sd0, 1'b0, 25'd0},
    '{31'sd0, 32'sd0, 31'sd0, 32'sd1800000000, 1'b0, 25'd0},
    '{31'sd0, -32'sd1800000000, 31'sd0, 32'sd1800000000, 1'b0, 25'd0},
    '{31'sd900000000, 32'sd0, -31'sd900000000, 32'sd0, 1'b0, 25'd0},
    '{-31'sd900000000, 32'sd1800000000, 31'sd900000000, -32'sd1800000000, 1'b0, 25'd0},
    '{31'sd0, 32'sd1800000000, 31'sd0, -32'sd1800000000, 1'b0, 25'd0},
    '{31'sd0, 32'sd2147483647, 31'sd0, -32'sd2147483648, 1'b0, 25'd0},
    '{31'sd0, -32'sd2147483648, 31'sd0, 32'sd2147483647, 1'b0, 25'd0},
    '{31'sd1073741823, 32'sd0, -31'sd1073741824, 32'sd0, 1'b0, 25'd0},
    '{-31'sd1073741824, 32'sd900000000, 31'sd1073741823, -32'sd900000000, 1'b0, 25'd0},
    '{31'sd0, 32'sd0, 31'sd0, 32'sd1, 1'b0, 25'd0},
    '{31'sd1, 32'sd1, -31'sd1, -32'sd1, 1'b0, 25'd0},
    '{31'sd450000000, 32'sd900000000, -31'sd450000000, -32'sd900000000, 1'b0, 25'd0},
    '{31'sd0, 32'sd0, 31'sd0, 32'sd1799999999, 1'b0, 25'd0},
    '{31'sd1, 32'sd0, -31'sd1, 32'sd1800000000, 1'b0, 25'd0},
    '{31'sd899999999, 32'sd123456789, 31'sd899999999, -32'sd987654321, 1'b0, 25'd0},
    '{31'sd0, 32'sd900000000, 31'sd0, -32'sd900000000, 1'b0, 25'd0}
  };

  function automatic pair_t random_pair();
    pair_t p;
    int mode;
    mode = $urandom_range(0, 9);
    p.known = 0;
    p.dist_m = 0;
    if (mode < 6) begin
      p.lat_a = 31'(longint'($urandom_range(0, 1800000000)) - 64'sd900000000);
      p.lat_b = 31'(longint'($urandom_range(0, 1800000000)) - 64'sd900000000);
      p.lon_a = 32'(longint'($urandom_range(0, 32'd3600000000)) - W_HALF);
      p.lon_b = 32'(longint'($urandom_range(0, 32'd3600000000)) - W_HALF);
    end else if (mode < 8) begin
      // nearby points
      p.lat_a = 31'(longint'($urandom_range(0, 1800000000)) - 64'sd900000000);
      p.lon_a = 32'(longint'($urandom_range(0, 32'd3600000000)) - W_HALF);
      p.lat_b = 31'(longint'(p.lat_a) + longint'($urandom_range(0, 2000)) - 64'sd1000);
      p.lon_b = 32'(longint'(p.lon_a) + longint'($urandom_range(0, 2000)) - 64'sd1000);
    end else begin
      // raw bits, covers out-of-range values and every bit
      p.lat_a = 31'($urandom);
      p.lat_b = 31'($urandom);
      p.lon_a = $urandom;
      p.lon_b = $urandom;
    end
    return p;
  endfunction

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // result side: compare each strobe with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      n_seen++;
      if (dist_q.size() == 0) begin
        report_mismatch("unexpected beat", out_distance_m, 25'd0);
      end else begin
        logic [24:0] want;
        want = dist_q.pop_front();
        if (out_distance_m !== want) report_mismatch("distance", out_distance_m, want);
      end
    end
  end

  task automatic send(input pair_t p, input bit calm);
    logic [24:0] want;
    while (!calm && $urandom_range(0, 99) < 7) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    in_lat_a <= p.lat_a;
    in_lon_a <= p.lon_a;
    in_lat_b <= p.lat_b;
    in_lon_b <= p.lon_b;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_distance(p, want);
    if (p.known && want !== p.dist_m) report_mismatch("table row", p.dist_m, want);
    dist_q.push_back(p.known ? p.dist_m : want);
    n_sent++;
  endtask

  initial begin
    int wait_n;
    cycles = 0;
    n_bad = 0;
    n_seen = 0;
    n_sent = 0;
    rst_n = 0;
    start = 0;
    in_lat_a = 0;
    in_lon_a = 0;
    in_lat_b = 0;
    in_lon_b = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (dir_tab[i]) send(dir_tab[i], 0);
    for (int i = 0; i < N_RAND; i++) send(random_pair(), (i >= 150 && i < 250));
    start <= 0;
    wait_n = 0;
    while (dist_q.size() != 0 && wait_n < 10 * LATENCY) begin
      @(posedge clk);
      wait_n++;
    end
    repeat (LATENCY) @(posedge clk);
    $display("sent %0d coordinate pairs, checked %0d distances", n_sent, n_seen);
    $display("covered poles, antimeridian wrap, out-of-range latitudes, random raw bits");
    if (n_bad == 0 && dist_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d distances missing", n_bad, dist_q.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/gcd_pkg.sv
sv/gcd_cordic.sv
sv/gcd_isqrt.sv
sv/great_circle_distance_unit.sv
tb/sv/tb_top.sv
